// ----- rtl/zpsag_pkg.sv -----
// Package for the zoom and pan scan-out address generator.
// Holds widths, limits, register codes and the structs passed between modules.
// No dependencies.
package zpsag_pkg;

    localparam int MAX_WIDTH  = 1280;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_ZOOM   = 256;

    localparam int DIM_W  = 11;
    localparam int COL_W  = 11;
    localparam int ROW_W  = 10;
    localparam int ZOOM_W = 9;
    localparam int REP_W  = 8;
    localparam int ADDR_W = 21;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    localparam int PROD_X_W = COL_W + 1 + ZOOM_W;
    localparam int PROD_Y_W = ROW_W + 1 + ZOOM_W;
    localparam int BASE_W   = DIM_W + DIM_W;
    localparam int CSUM_W   = COL_W + 1;
    localparam int ASUM_W   = BASE_W + 1;

    localparam logic [DIM_W-1:0]  WIDTH_MAX  = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0]  HEIGHT_MAX = DIM_W'(MAX_HEIGHT);
    localparam logic [ZOOM_W-1:0] ZOOM_MAX   = ZOOM_W'(MAX_ZOOM);
    localparam logic [COL_W-1:0]  WIN_X_MAX  = COL_W'(MAX_WIDTH - 1);
    localparam logic [ROW_W-1:0]  WIN_Y_MAX  = ROW_W'(MAX_HEIGHT - 1);

    localparam logic [DIM_W-1:0]  FRAME_DIM_RST = DIM_W'(512);
    localparam logic [ZOOM_W-1:0] ZOOM_RST      = ZOOM_W'(1);

    typedef enum logic [2:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_ZOOM_X       = 3'd2,
        REG_ZOOM_Y       = 3'd3,
        REG_WINDOW_X     = 3'd4,
        REG_WINDOW_Y     = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [DIM_W-1:0]  frame_width;
        logic [DIM_W-1:0]  frame_height;
        logic [ZOOM_W-1:0] zoom_x;
        logic [ZOOM_W-1:0] zoom_y;
        logic [COL_W-1:0]  window_x;
        logic [ROW_W-1:0]  window_y;
    } cfg_t;

    typedef struct packed {
        logic [COL_W-1:0] src_col;
        logic [ROW_W-1:0] src_row;
        logic             row_end;
        logic             frame_end;
    } coord_t;

    typedef struct packed {
        logic [PROD_X_W-1:0] col_prod;
        logic [PROD_Y_W-1:0] row_prod;
        logic [BASE_W-1:0]   base;
        logic [CSUM_W-1:0]   col_sum;
        logic                row_end;
        logic                frame_end;
    } prod_t;

endpackage

// ----- rtl/zpsag_if.sv -----
// Channel interfaces for the scan-out address generator: the tick input and
// the pixel result. Depends on zpsag_pkg for the address width.
interface zpsag_tick_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface zpsag_pixel_if import zpsag_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] src_addr;
    logic              blank;
    logic              row_end;
    logic              frame_end;

    modport source (output valid, output src_addr, output blank, output row_end,
                    output frame_end, input ready);
    modport sink (input valid, input src_addr, input blank, input row_end,
                  input frame_end, output ready);
endinterface

// ----- rtl/zpsag_cfg.sv -----
// APB register file for frame size, zoom factors and window origin.
// Saturates every write to its legal range. Depends on zpsag_pkg.
module zpsag_cfg import zpsag_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [DIM_W-1:0]  frame_width_reg;
    logic [DIM_W-1:0]  frame_height_reg;
    logic [ZOOM_W-1:0] zoom_x_reg;
    logic [ZOOM_W-1:0] zoom_y_reg;
    logic [COL_W-1:0]  window_x_reg;
    logic [ROW_W-1:0]  window_y_reg;

    logic              wr_en;
    reg_idx_t          idx;
    logic [DIM_W-1:0]  wd_dim;
    logic [ZOOM_W-1:0] wd_zoom;
    logic [COL_W-1:0]  wd_col;
    logic [ROW_W-1:0]  wd_row;
    logic [DIM_W-1:0]  width_sat;
    logic [DIM_W-1:0]  height_sat;
    logic [ZOOM_W-1:0] zoom_sat;
    logic [COL_W-1:0]  win_x_sat;
    logic [ROW_W-1:0]  win_y_sat;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);

    assign wd_dim  = pwdata[DIM_W-1:0];
    assign wd_zoom = pwdata[ZOOM_W-1:0];
    assign wd_col  = pwdata[COL_W-1:0];
    assign wd_row  = pwdata[ROW_W-1:0];

    assign width_sat  = (wd_dim == '0) ? DIM_W'(1) :
                        (wd_dim > WIDTH_MAX) ? WIDTH_MAX : wd_dim;
    assign height_sat = (wd_dim == '0) ? DIM_W'(1) :
                        (wd_dim > HEIGHT_MAX) ? HEIGHT_MAX : wd_dim;
    assign zoom_sat   = (wd_zoom == '0) ? ZOOM_W'(1) :
                        (wd_zoom > ZOOM_MAX) ? ZOOM_MAX : wd_zoom;
    assign win_x_sat  = (wd_col > WIN_X_MAX) ? WIN_X_MAX : wd_col;
    assign win_y_sat  = (wd_row > WIN_Y_MAX) ? WIN_Y_MAX : wd_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_DIM_RST;
            frame_height_reg <= FRAME_DIM_RST;
            zoom_x_reg       <= ZOOM_RST;
            zoom_y_reg       <= ZOOM_RST;
            window_x_reg     <= '0;
            window_y_reg     <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_FRAME_WIDTH:  frame_width_reg  <= width_sat;
                REG_FRAME_HEIGHT: frame_height_reg <= height_sat;
                REG_ZOOM_X:       zoom_x_reg       <= zoom_sat;
                REG_ZOOM_Y:       zoom_y_reg       <= zoom_sat;
                REG_WINDOW_X:     window_x_reg     <= win_x_sat;
                REG_WINDOW_Y:     window_y_reg     <= win_y_sat;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_FRAME_WIDTH:  prdata = APB_DW'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DW'(frame_height_reg);
            REG_ZOOM_X:       prdata = APB_DW'(zoom_x_reg);
            REG_ZOOM_Y:       prdata = APB_DW'(zoom_y_reg);
            REG_WINDOW_X:     prdata = APB_DW'(window_x_reg);
            REG_WINDOW_Y:     prdata = APB_DW'(window_y_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.frame_width  = frame_width_reg;
    assign cfg.frame_height = frame_height_reg;
    assign cfg.zoom_x       = zoom_x_reg;
    assign cfg.zoom_y       = zoom_y_reg;
    assign cfg.window_x     = window_x_reg;
    assign cfg.window_y     = window_y_reg;

endmodule

// ----- rtl/zpsag_scan.sv -----
// Raster scan counters and the first pipeline stage: takes one tick beat per
// cycle unless stage one is stalled, and registers the source offsets and
// line and frame end flags. Depends on zpsag_pkg and zpsag_tick_if.
module zpsag_scan import zpsag_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    zpsag_tick_if.sink  tick,
    input  logic        s1_take,
    output logic        s1_valid,
    output coord_t      s1_coord
);

    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic [COL_W-1:0] src_col_reg, src_col_next;
    logic [REP_W-1:0] rep_x_reg, rep_x_next;
    logic [ROW_W-1:0] src_row_reg, src_row_next;
    logic [REP_W-1:0] rep_y_reg, rep_y_next;
    logic             valid_reg;
    coord_t           coord_reg, coord_next;

    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
    logic [COL_W-1:0]  cur_src_col;
    logic [REP_W-1:0]  cur_rep_x;
    logic [ROW_W-1:0]  cur_src_row;
    logic [REP_W-1:0]  cur_rep_y;
    logic [ZOOM_W-1:0] rep_x_inc;
    logic [ZOOM_W-1:0] rep_y_inc;
    logic              row_end;
    logic              frame_end;
    logic              accept;

    assign tick.ready = !valid_reg || s1_take;
    assign accept     = tick.valid && tick.ready;

    assign cur_col     = tick.restart ? '0 : out_col_reg;
    assign cur_row     = tick.restart ? '0 : out_row_reg;
    assign cur_src_col = tick.restart ? '0 : src_col_reg;
    assign cur_rep_x   = tick.restart ? '0 : rep_x_reg;
    assign cur_src_row = tick.restart ? '0 : src_row_reg;
    assign cur_rep_y   = tick.restart ? '0 : rep_y_reg;

    assign rep_x_inc = ZOOM_W'(cur_rep_x) + ZOOM_W'(1);
    assign rep_y_inc = ZOOM_W'(cur_rep_y) + ZOOM_W'(1);

    assign row_end   = DIM_W'(cur_col) >= (cfg.frame_width - DIM_W'(1));
    assign frame_end = row_end && (DIM_W'(cur_row) >= (cfg.frame_height - DIM_W'(1)));

    always_comb
    begin
        out_col_next = cur_col;
        out_row_next = cur_row;
        src_col_next = cur_src_col;
        rep_x_next   = cur_rep_x;
        src_row_next = cur_src_row;
        rep_y_next   = cur_rep_y;
        if (frame_end)
        begin
            out_col_next = '0;
            out_row_next = '0;
            src_col_next = '0;
            rep_x_next   = '0;
            src_row_next = '0;
            rep_y_next   = '0;
        end
        else if (row_end)
        begin
            out_col_next = '0;
            src_col_next = '0;
            rep_x_next   = '0;
            if (rep_y_inc >= cfg.zoom_y)
            begin
                rep_y_next   = '0;
                src_row_next = cur_src_row + ROW_W'(1);
            end
            else
            begin
                rep_y_next = rep_y_inc[REP_W-1:0];
            end
            out_row_next = cur_row + ROW_W'(1);
        end
        else
        begin
            if (rep_x_inc >= cfg.zoom_x)
            begin
                rep_x_next   = '0;
                src_col_next = cur_src_col + COL_W'(1);
            end
            else
            begin
                rep_x_next = rep_x_inc[REP_W-1:0];
            end
            out_col_next = cur_col + COL_W'(1);
        end

        coord_next.src_col   = cur_src_col;
        coord_next.src_row   = cur_src_row;
        coord_next.row_end   = row_end;
        coord_next.frame_end = frame_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_col_reg <= '0;
            out_row_reg <= '0;
            src_col_reg <= '0;
            rep_x_reg   <= '0;
            src_row_reg <= '0;
            rep_y_reg   <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                out_col_reg <= out_col_next;
                out_row_reg <= out_row_next;
                src_col_reg <= src_col_next;
                rep_x_reg   <= rep_x_next;
                src_row_reg <= src_row_next;
                rep_y_reg   <= rep_y_next;
            end
            if (tick.ready)
            begin
                valid_reg <= tick.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            coord_reg <= coord_next;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_coord = coord_reg;

endmodule

// ----- rtl/zpsag_addr.sv -----
// Address stages: products of offsets and zoom plus the row base, then the
// window fit test and the final address into the result register.
// Depends on zpsag_pkg and zpsag_pixel_if.
module zpsag_addr import zpsag_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  logic          s1_valid,
    input  coord_t        s1_coord,
    output logic          s1_take,
    zpsag_pixel_if.source pixel
);

    logic              s2_valid_reg;
    prod_t             s2_reg, s2_next;
    logic              s3_valid_reg;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              blank_reg, blank_next;
    logic              row_end_reg;
    logic              frame_end_reg;

    logic              s2_en;
    logic              s3_en;
    logic [DIM_W-1:0]  col_room;
    logic [DIM_W-1:0]  row_room;
    logic              col_fit;
    logic              row_fit;
    logic [ASUM_W-1:0] addr_sum;

    assign s3_en   = !s3_valid_reg || pixel.ready;
    assign s2_en   = !s2_valid_reg || s3_en;
    assign s1_take = s2_en;

    always_comb
    begin
        s2_next.col_prod  = PROD_X_W'(CSUM_W'(s1_coord.src_col) + CSUM_W'(1))
                            * PROD_X_W'(cfg.zoom_x);
        s2_next.row_prod  = PROD_Y_W'((ROW_W + 1)'(s1_coord.src_row) + (ROW_W + 1)'(1))
                            * PROD_Y_W'(cfg.zoom_y);
        s2_next.base      = BASE_W'(DIM_W'(cfg.window_y) + DIM_W'(s1_coord.src_row))
                            * BASE_W'(cfg.frame_width);
        s2_next.col_sum   = CSUM_W'(cfg.window_x) + CSUM_W'(s1_coord.src_col);
        s2_next.row_end   = s1_coord.row_end;
        s2_next.frame_end = s1_coord.frame_end;
    end

    assign col_room = cfg.frame_width - DIM_W'(cfg.window_x);
    assign row_room = cfg.frame_height - DIM_W'(cfg.window_y);
    assign col_fit  = (DIM_W'(cfg.window_x) < cfg.frame_width)
                      && (s2_reg.col_prod <= PROD_X_W'(col_room));
    assign row_fit  = (DIM_W'(cfg.window_y) < cfg.frame_height)
                      && (s2_reg.row_prod <= PROD_Y_W'(row_room));
    assign addr_sum = ASUM_W'(s2_reg.base) + ASUM_W'(s2_reg.col_sum);

    assign blank_next = !(col_fit && row_fit);
    assign addr_next  = blank_next ? '0 : addr_sum[ADDR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid;
            end
            if (s3_en)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_en && s1_valid)
        begin
            s2_reg <= s2_next;
        end
        if (s3_en && s2_valid_reg)
        begin
            addr_reg      <= addr_next;
            blank_reg     <= blank_next;
            row_end_reg   <= s2_reg.row_end;
            frame_end_reg <= s2_reg.frame_end;
        end
    end

    assign pixel.valid     = s3_valid_reg;
    assign pixel.src_addr  = addr_reg;
    assign pixel.blank     = blank_reg;
    assign pixel.row_end   = row_end_reg;
    assign pixel.frame_end = frame_end_reg;

endmodule

// ----- rtl/zoom_pan_scanout_address_gen_top.sv -----
// Top level of the zoom and pan scan-out address generator.
// Depends on zpsag_pkg, zpsag_if, zpsag_cfg, zpsag_scan and zpsag_addr.
//
//   Channel  Direction  Beat contents
//   tick     in         restart
//   pixel    out        src_addr, blank, row_end, frame_end
//   apb      in/out     frame_width, frame_height, zoom_x, zoom_y, window_x, window_y
//
// One tick beat is taken every cycle unless the pipeline is stalled; its pixel is registered in
// stage one, stage two and the result register. The rate is set by the scan counter update.
// Reset restores the register defaults and clears the scan to pixel (0,0).
// When pixel is stalled, up to three beats are held before tick is stalled.
module zoom_pan_scanout_address_gen_top import zpsag_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    zpsag_tick_if.sink        tick,
    zpsag_pixel_if.source     pixel
);

    cfg_t   cfg;
    logic   s1_valid;
    logic   s1_take;
    coord_t s1_coord;

    zpsag_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    zpsag_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .tick     (tick),
        .s1_take  (s1_take),
        .s1_valid (s1_valid),
        .s1_coord (s1_coord)
    );

    zpsag_addr u_addr (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .s1_valid (s1_valid),
        .s1_coord (s1_coord),
        .s1_take  (s1_take),
        .pixel    (pixel)
    );

    // A blank pixel carries a zero address.
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel.valid && pixel.blank |-> pixel.src_addr == '0)
        else $error("blank pixel with non-zero address");

    // The last pixel of a frame is also the last of its line.
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel.valid && pixel.frame_end |-> pixel.row_end)
        else $error("frame end without row end");

    // A visible pixel always addresses inside the frame store.
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel.valid && !pixel.blank |->
        BASE_W'(pixel.src_addr) < (BASE_W'(cfg.frame_height) * BASE_W'(cfg.frame_width)))
        else $error("visible pixel addresses outside the frame");

    // A stage-one beat waiting on a stalled pipeline keeps the tick side stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid && !s1_take |-> !tick.ready)
        else $error("tick taken while stage one is blocked");

endmodule

// ----- verif/zoom_pan_scanout_address_gen_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the zoom and pan scan-out address generator top level.
// Drives tick beats and APB register accesses, predicts every pixel beat and checks it.
// Depends on zpsag_pkg, the channel interfaces in zpsag_if and the block's RTL.
module zoom_pan_scanout_address_gen_top_tb;
    import zpsag_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 4;
    localparam int MAX_IDLE     = 5;
    localparam int HOLD_CYCLES  = 40;
    localparam int RANDOM_ITEMS = 150;
    localparam int REPORT_LIMIT = 10;

    localparam logic [2:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [2:0] REG_UNMAPPED_HI = 3'd7;

    typedef struct packed {
        logic [ADDR_W-1:0] src_addr;
        logic              blank;
        logic              row_end;
        logic              frame_end;
    } pixel_beat_t;

    typedef struct packed {
        logic [COL_W-1:0] out_col;
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] col_off;
        logic [REP_W-1:0] rep_x;
        logic [ROW_W-1:0] row_off;
        logic [REP_W-1:0] rep_y;
    } scan_pos_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    zpsag_tick_if  tick_if ();
    zpsag_pixel_if pixel_if ();

    zoom_pan_scanout_address_gen_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .tick    (tick_if),
        .pixel   (pixel_if)
    );

    cfg_t        model_cfg = '{FRAME_DIM_RST, FRAME_DIM_RST, ZOOM_RST, ZOOM_RST, '0, '0};
    scan_pos_t   scan_pos  = '0;
    pixel_beat_t pixel_expect_q [$];

    int   mismatches    = 0;
    int   ticks_sent    = 0;
    int   restarts_sent = 0;
    int   pixels_seen   = 0;
    int   frames_seen   = 0;
    int   reg_writes    = 0;
    int   cycle_count   = 0;
    int   tick_gap_max  = MAX_IDLE;
    int   pixel_stall_max = MAX_IDLE;
    logic pixel_hold    = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int unsigned exp_v,
                                   input int unsigned act_v);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
        begin
            $display("%0t %s: expected %0d, got %0d", $time, what, exp_v, act_v);
        end
    endtask

    function automatic int unsigned clamp(input int unsigned v, input int unsigned lo,
                                          input int unsigned hi);
        if (v < lo)
        begin
            return lo;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    function automatic logic [APB_DW-1:0] model_reg(input logic [2:0] idx);
        case (idx)
            REG_FRAME_WIDTH:  return APB_DW'(model_cfg.frame_width);
            REG_FRAME_HEIGHT: return APB_DW'(model_cfg.frame_height);
            REG_ZOOM_X:       return APB_DW'(model_cfg.zoom_x);
            REG_ZOOM_Y:       return APB_DW'(model_cfg.zoom_y);
            REG_WINDOW_X:     return APB_DW'(model_cfg.window_x);
            REG_WINDOW_Y:     return APB_DW'(model_cfg.window_y);
            default:          return '0;
        endcase
    endfunction

    // Works out the pixel for one accepted tick and advances the scan position.
    task automatic predict_pixel(input logic restart);
        int unsigned fw, fh, zx, zy, wx, wy;
        int unsigned oc, orow, co, ro, rx, ry;
        logic        col_fit, row_fit;
        pixel_beat_t beat;
        if (restart)
        begin
            scan_pos = '0;
        end
        fw = model_cfg.frame_width;
        fh = model_cfg.frame_height;
        zx = model_cfg.zoom_x;
        zy = model_cfg.zoom_y;
        wx = model_cfg.window_x;
        wy = model_cfg.window_y;
        oc   = scan_pos.out_col;
        orow = scan_pos.out_row;
        co   = scan_pos.col_off;
        ro   = scan_pos.row_off;
        rx   = scan_pos.rep_x;
        ry   = scan_pos.rep_y;

        col_fit = (wx < fw) && ((co + 1) * zx <= fw - wx);
        row_fit = (wy < fh) && ((ro + 1) * zy <= fh - wy);
        beat.blank     = !(col_fit && row_fit);
        beat.src_addr  = beat.blank ? '0 : ADDR_W'((wy + ro) * fw + wx + co);
        beat.row_end   = oc >= fw - 1;
        beat.frame_end = beat.row_end && (orow >= fh - 1);
        pixel_expect_q.push_back(beat);

        if (beat.frame_end)
        begin
            scan_pos = '0;
        end
        else if (beat.row_end)
        begin
            scan_pos.out_col = '0;
            scan_pos.col_off = '0;
            scan_pos.rep_x   = '0;
            if (ry + 1 >= zy)
            begin
                scan_pos.rep_y   = '0;
                scan_pos.row_off = scan_pos.row_off + 1'b1;
            end
            else
            begin
                scan_pos.rep_y = scan_pos.rep_y + 1'b1;
            end
            scan_pos.out_row = scan_pos.out_row + 1'b1;
        end
        else
        begin
            if (rx + 1 >= zx)
            begin
                scan_pos.rep_x   = '0;
                scan_pos.col_off = scan_pos.col_off + 1'b1;
            end
            else
            begin
                scan_pos.rep_x = scan_pos.rep_x + 1'b1;
            end
            scan_pos.out_col = scan_pos.out_col + 1'b1;
        end
    endtask

    task automatic send_tick(input logic restart);
        int gap;
        gap = $urandom_range(0, tick_gap_max);
        if (gap > 0)
        begin
            tick_if.valid   <= 1'b0;
            tick_if.restart <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge clk);
        end
        tick_if.valid   <= 1'b1;
        tick_if.restart <= restart;
        @(posedge clk);
        while (!tick_if.ready)
        begin
            @(posedge clk);
        end
        predict_pixel(restart);
        ticks_sent++;
        if (restart)
        begin
            restarts_sent++;
        end
    endtask

    task automatic wait_idle();
        tick_if.valid <= 1'b0;
        while (pixel_expect_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input logic write, input logic [2:0] idx,
                              input logic [APB_DW-1:0] wdata,
                              output logic [APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_reg(input logic [2:0] idx);
        logic [APB_DW-1:0] rdata;
        apb_access(1'b0, idx, '0, rdata);
        if (rdata !== model_reg(idx))
        begin
            report_mismatch($sformatf("register %0d readback", idx), model_reg(idx), rdata);
        end
    endtask

    task automatic check_all_regs();
        for (int i = 0; i <= int'(REG_WINDOW_Y); i++)
        begin
            check_reg(3'(i));
        end
    endtask

    task automatic set_reg(input logic [2:0] idx, input logic [APB_DW-1:0] value);
        logic [APB_DW-1:0] unused;
        apb_access(1'b1, idx, value, unused);
        reg_writes++;
        case (idx)
            REG_FRAME_WIDTH:
                model_cfg.frame_width  = DIM_W'(clamp(value[DIM_W-1:0], 1, MAX_WIDTH));
            REG_FRAME_HEIGHT:
                model_cfg.frame_height = DIM_W'(clamp(value[DIM_W-1:0], 1, MAX_HEIGHT));
            REG_ZOOM_X:
                model_cfg.zoom_x   = ZOOM_W'(clamp(value[ZOOM_W-1:0], 1, MAX_ZOOM));
            REG_ZOOM_Y:
                model_cfg.zoom_y   = ZOOM_W'(clamp(value[ZOOM_W-1:0], 1, MAX_ZOOM));
            REG_WINDOW_X:
                model_cfg.window_x = COL_W'(clamp(value[COL_W-1:0], 0, MAX_WIDTH - 1));
            REG_WINDOW_Y:
                model_cfg.window_y = ROW_W'(clamp(value[ROW_W-1:0], 0, MAX_HEIGHT - 1));
            default:
                ;
        endcase
        if (idx <= REG_WINDOW_Y)
        begin
            check_reg(idx);
        end
    endtask

    initial
    begin : pixel_monitor
        int          stall_left;
        pixel_beat_t exp_beat;
        stall_left = 0;
        pixel_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (pixel_if.valid && pixel_if.ready)
            begin
                pixels_seen++;
                if (pixel_if.frame_end)
                begin
                    frames_seen++;
                end
                if (pixel_expect_q.size() == 0)
                begin
                    report_mismatch("pixel beat with nothing expected, src_addr", 0,
                                    pixel_if.src_addr);
                end
                else
                begin
                    exp_beat = pixel_expect_q.pop_front();
                    if (pixel_if.src_addr !== exp_beat.src_addr)
                    begin
                        report_mismatch("src_addr", exp_beat.src_addr, pixel_if.src_addr);
                    end
                    if (pixel_if.blank !== exp_beat.blank)
                    begin
                        report_mismatch("blank", exp_beat.blank, pixel_if.blank);
                    end
                    if (pixel_if.row_end !== exp_beat.row_end)
                    begin
                        report_mismatch("row_end", exp_beat.row_end, pixel_if.row_end);
                    end
                    if (pixel_if.frame_end !== exp_beat.frame_end)
                    begin
                        report_mismatch("frame_end", exp_beat.frame_end, pixel_if.frame_end);
                    end
                end
                stall_left = $urandom_range(0, pixel_stall_max);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
            end
            pixel_if.ready <= rst_n && (stall_left == 0) && !pixel_hold;
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d beats outstanding.", cycle_count,
                 pixel_expect_q.size());
        $display("zoom_pan_scanout_address_gen_top verification failed");
        $finish;
    end

    task automatic test_reset_values();
        check_all_regs();
        for (int i = 0; i < 7; i++)
        begin
            send_tick(i == 4);
        end
        wait_idle();
    endtask

    task automatic test_register_limits();
        set_reg(REG_FRAME_WIDTH, '0);
        set_reg(REG_FRAME_WIDTH, '1);
        set_reg(REG_FRAME_WIDTH, 32'h0000_0800);
        set_reg(REG_FRAME_HEIGHT, 32'd1025);
        set_reg(REG_FRAME_HEIGHT, '0);
        set_reg(REG_ZOOM_X, '0);
        set_reg(REG_ZOOM_X, 32'd257);
        set_reg(REG_ZOOM_Y, '1);
        set_reg(REG_ZOOM_Y, 32'h0000_0200);
        set_reg(REG_WINDOW_X, '1);
        set_reg(REG_WINDOW_X, 32'd1280);
        set_reg(REG_WINDOW_Y, '1);
        set_reg(REG_WINDOW_Y, 32'h0000_0400);
        set_reg(REG_UNMAPPED_LO, '1);
        set_reg(REG_UNMAPPED_HI, '1);
        check_all_regs();
    endtask

    task automatic test_extreme_window();
        set_reg(REG_FRAME_WIDTH, MAX_WIDTH);
        set_reg(REG_FRAME_HEIGHT, MAX_HEIGHT);
        set_reg(REG_ZOOM_X, MAX_ZOOM);
        set_reg(REG_ZOOM_Y, MAX_ZOOM);
        set_reg(REG_WINDOW_X, MAX_WIDTH - 1);
        set_reg(REG_WINDOW_Y, MAX_HEIGHT - 1);
        send_tick(1'b1);
        send_tick(1'b0);
        wait_idle();
        set_reg(REG_WINDOW_X, MAX_WIDTH - MAX_ZOOM);
        set_reg(REG_WINDOW_Y, MAX_HEIGHT - MAX_ZOOM);
        send_tick(1'b1);
        send_tick(1'b0);
        wait_idle();
        set_reg(REG_ZOOM_X, 1);
        set_reg(REG_ZOOM_Y, 1);
        set_reg(REG_WINDOW_X, MAX_WIDTH - 1);
        set_reg(REG_WINDOW_Y, MAX_HEIGHT - 1);
        send_tick(1'b1);
        send_tick(1'b0);
        wait_idle();
        set_reg(REG_FRAME_WIDTH, 16);
        set_reg(REG_WINDOW_X, 20);
        send_tick(1'b0);
        send_tick(1'b0);
        wait_idle();
    endtask

    task automatic test_small_frame();
        set_reg(REG_FRAME_WIDTH, 4);
        set_reg(REG_FRAME_HEIGHT, 3);
        set_reg(REG_ZOOM_X, 2);
        set_reg(REG_ZOOM_Y, 2);
        set_reg(REG_WINDOW_X, 1);
        set_reg(REG_WINDOW_Y, 1);
        send_tick(1'b1);
        for (int i = 1; i < 14; i++)
        begin
            send_tick(i == 7);
        end
        wait_idle();
    endtask

    task automatic test_long_scan();
        tick_gap_max    = 0;
        pixel_stall_max = 1;
        set_reg(REG_FRAME_WIDTH, 258);
        set_reg(REG_FRAME_HEIGHT, 2);
        set_reg(REG_ZOOM_X, MAX_ZOOM);
        set_reg(REG_ZOOM_Y, 1);
        set_reg(REG_WINDOW_X, 0);
        set_reg(REG_WINDOW_Y, 0);
        send_tick(1'b1);
        for (int i = 1; i < 262; i++)
        begin
            send_tick(1'b0);
        end
        wait_idle();
        set_reg(REG_FRAME_WIDTH, 1);
        set_reg(REG_FRAME_HEIGHT, 258);
        set_reg(REG_ZOOM_X, 1);
        set_reg(REG_ZOOM_Y, MAX_ZOOM);
        send_tick(1'b1);
        for (int i = 1; i < 262; i++)
        begin
            send_tick(1'b0);
        end
        wait_idle();
        tick_gap_max    = MAX_IDLE;
        pixel_stall_max = MAX_IDLE;
    endtask

    task automatic test_backpressure();
        set_reg(REG_FRAME_WIDTH, 6);
        set_reg(REG_FRAME_HEIGHT, 4);
        set_reg(REG_ZOOM_X, 2);
        set_reg(REG_ZOOM_Y, 3);
        tick_gap_max    = 0;
        pixel_stall_max = 0;
        fork
            begin
                pixel_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                pixel_hold <= 1'b0;
            end
        join_none
        for (int i = 0; i < 30; i++)
        begin
            send_tick(1'b0);
        end
        wait_idle();
        pixel_stall_max = MAX_IDLE;
        for (int i = 0; i < 20; i++)
        begin
            send_tick(1'b0);
        end
        wait_idle();
        tick_gap_max = MAX_IDLE;
    endtask

    task automatic randomise_regs();
        logic [APB_DW-1:0] value;
        for (int i = 0; i <= int'(REG_WINDOW_Y); i++)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                continue;
            end
            case ($urandom_range(0, 7))
                0: value = $urandom();
                1: value = $urandom_range(0, 1) ? {APB_DW{1'b1}} : {APB_DW{1'b0}};
                default:
                    case (3'(i))
                        REG_FRAME_WIDTH:  value = $urandom_range(1, 12);
                        REG_FRAME_HEIGHT: value = $urandom_range(1, 8);
                        REG_WINDOW_X:     value = $urandom_range(0, model_cfg.frame_width + 1);
                        REG_WINDOW_Y:     value = $urandom_range(0, model_cfg.frame_height + 1);
                        default:          value = $urandom_range(1, 4);
                    endcase
            endcase
            set_reg(3'(i), value);
        end
    endtask

    task automatic test_random();
        int start_count;
        int burst;
        start_count = ticks_sent;
        while (ticks_sent - start_count < RANDOM_ITEMS)
        begin
            wait_idle();
            randomise_regs();
            tick_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
            pixel_stall_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
            burst = $urandom_range(5, 40);
            send_tick($urandom_range(0, 2) == 0);
            for (int i = 1; i < burst; i++)
            begin
                send_tick($urandom_range(0, 24) == 0);
            end
        end
        wait_idle();
    endtask

    initial
    begin : stimulus
        rst_n           <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        tick_if.valid   <= 1'b0;
        tick_if.restart <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_register_limits();
        test_extreme_window();
        test_small_frame();
        test_long_scan();
        test_backpressure();
        test_random();

        $display("Run covered %0d ticks (%0d restarts) and %0d pixel beats over %0d frame ends,",
                 ticks_sent, restarts_sent, pixels_seen, frames_seen);
        $display("with %0d register writes in %0d cycles; %0d mismatches found.",
                 reg_writes, cycle_count, mismatches);
        if (mismatches == 0 && pixel_expect_q.size() == 0)
        begin
            $display("zoom_pan_scanout_address_gen_top verification clean");
        end
        else
        begin
            $display("zoom_pan_scanout_address_gen_top verification failed");
        end
        $finish;
    end

endmodule
